FILE: rtl/hidrdp_pkg.sv
// Package for the HID report descriptor parser: constants, codes and the
// item word passed from the byte assembler to the table engine. No dependencies.
`default_nettype none
package hidrdp_pkg;
   localparam int STACK_DEPTH = 4;
   localparam int MAX_NEST    = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SI_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NEST_W      = $clog2(MAX_NEST + 1);

   localparam logic [3:0] TAG_LONG       = 4'hF;
   localparam logic [3:0] TAG_COLLECTION = 4'hA;
   localparam logic [3:0] TAG_END_COLL   = 4'hC;
   localparam logic [3:0] TAG_PUSH       = 4'hA;
   localparam logic [3:0] TAG_POP        = 4'hB;
   localparam logic [3:0] G_USAGE_PAGE   = 4'd0;
   localparam logic [3:0] G_REPORT_SIZE  = 4'd7;
   localparam logic [3:0] G_REPORT_ID    = 4'd8;
   localparam logic [3:0] G_REPORT_COUNT = 4'd9;
   localparam logic [3:0] L_USAGE        = 4'd0;

   typedef enum logic [1:0] {
      ITYPE_MAIN = 2'd0, ITYPE_GLOBAL = 2'd1, ITYPE_LOCAL = 2'd2, ITYPE_RSVD = 2'd3
   } itype_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0, PH_LSIZE = 2'd1, PH_LTAG = 2'd2, PH_DATA = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_POP_EMPTY = 3'd1, ST_PUSH_OVF = 3'd2,
      ST_DEPTH_UNF = 3'd3, ST_TRUNC = 3'd4
   } status_type;

   // One assembled item, handed from the front to the back.
   typedef struct packed {
      logic       is_long;
      itype_type  itype;
      logic [7:0] tag;
      logic [7:0] size;
      logic [31:0] value;
      logic       trunc;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        is_long;
      logic [1:0]  itype;
      logic [7:0]  item_tag;
      logic [7:0]  data_size;
      logic [31:0] data_value;
      logic [4:0]  nest_depth;
      logic [31:0] usage_page;
      logic [31:0] report_size;
      logic [31:0] report_id;
      logic [31:0] report_count;
      logic [31:0] local_usage;
      logic [2:0]  status;
   } rec_type;
endpackage
`default_nettype wire

FILE: rtl/hidrdp_front.sv
// Front end: assembles descriptor bytes into items (short and long).
// Depends on hidrdp_pkg.
`default_nettype none
module hidrdp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_last,
   output logic                     item_valid,
   output hidrdp_pkg::item_type     item
);
   hidrdp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [31:0] val_ff, val_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hidrdp_pkg::PH_HEADER;
         left_ff  <= '0;
         len_ff   <= '0;
         hdr_ff   <= '0;
         val_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         len_ff   <= len_in;
         hdr_ff   <= hdr_in;
         val_ff   <= val_in;
      end
   end

   always_comb begin
      logic       done;
      logic [7:0] got;
      logic [7:0] left_dec;
      logic [1:0] code;
      phase_in = phase_ff;
      left_in  = left_ff;
      len_in   = len_ff;
      hdr_in   = hdr_ff;
      val_in   = val_ff;
      done     = 1'b0;
      got      = len_ff - left_ff;
      left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
      code     = in_byte[1:0];
      if (in_valid) begin
         case (phase_ff)
            hidrdp_pkg::PH_HEADER: begin
               hdr_in  = {8'd0, in_byte};
               val_in  = '0;
               len_in  = '0;
               left_in = '0;
               if (in_byte[7:4] == hidrdp_pkg::TAG_LONG) begin
                  phase_in = hidrdp_pkg::PH_LSIZE;
               end else begin
                  len_in  = (code == 2'd3) ? 8'd4 : {6'd0, code};
                  left_in = len_in;
                  if (code == 2'd0) done = 1'b1;
                  else phase_in = hidrdp_pkg::PH_DATA;
               end
            end
            hidrdp_pkg::PH_LSIZE: begin
               len_in   = in_byte;
               left_in  = in_byte;
               phase_in = hidrdp_pkg::PH_LTAG;
            end
            hidrdp_pkg::PH_LTAG: begin
               hdr_in = {in_byte, hdr_ff[7:0]};
               if (len_ff == 8'd0) done = 1'b1;
               else phase_in = hidrdp_pkg::PH_DATA;
            end
            default: begin
               if (got < 8'd4) begin
                  case (got[1:0])
                     2'd0: val_in[7:0]   = in_byte;
                     2'd1: val_in[15:8]  = in_byte;
                     2'd2: val_in[23:16] = in_byte;
                     default: val_in[31:24] = in_byte;
                  endcase
               end
               left_in = left_dec;
               if (left_dec == 8'd0) done = 1'b1;
            end
         endcase
         if (done) phase_in = hidrdp_pkg::PH_HEADER;
      end
      item_valid   = in_valid && (done || in_last);
      item.is_long = hdr_in[7:4] == hidrdp_pkg::TAG_LONG;
      item.itype   = hidrdp_pkg::itype_type'(hdr_in[3:2]);
      item.tag     = item.is_long ? hdr_in[15:8] : {4'd0, hdr_in[7:4]};
      item.size    = len_in;
      item.value   = val_in;
      item.trunc   = !done;
      item.last    = in_last;
      if (in_valid && in_last) begin
         phase_in = hidrdp_pkg::PH_HEADER;
         left_in  = '0;
         len_in   = '0;
         hdr_in   = '0;
         val_in   = '0;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/hidrdp_queue.sv
// Two-entry queue carrying items from the front end to the table engine.
// Depends on hidrdp_pkg.
`default_nettype none
module hidrdp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire hidrdp_pkg::item_type wr_item,
   output logic                      full,
   input  wire logic                 rd_en,
   output logic                      empty,
   output hidrdp_pkg::item_type      rd_item
);
   hidrdp_pkg::item_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= !wp_ff;
         if (rd_en) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_en} - {1'b0, rd_en};
      end
      if (wr_en) mem_ff[wp_ff] <= wr_item;
   end

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign rd_item = mem_ff[rp_ff];
endmodule
`default_nettype wire

FILE: rtl/hidrdp_back.sv
// Back end: applies items to the global, local and stack tables and builds
// records into a two-entry output queue. Depends on hidrdp_pkg.
`default_nettype none
module hidrdp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_empty,
   input  wire hidrdp_pkg::item_type in_item,
   output logic                      in_pop,
   input  wire logic                 out_pop,
   output logic                      out_empty,
   output hidrdp_pkg::rec_type       out_rec
);
   logic [31:0] gt_ff [16];
   logic [31:0] gs_ff [hidrdp_pkg::STACK_DEPTH][16];
   logic [31:0] lu_ff;
   logic [hidrdp_pkg::SP_W-1:0]   sp_ff;
   logic [hidrdp_pkg::NEST_W-1:0] nest_ff;
   hidrdp_pkg::rec_type q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   logic [31:0] gt_in [16];
   logic [31:0] lu_in;
   logic [hidrdp_pkg::SP_W-1:0]   sp_in;
   logic [hidrdp_pkg::NEST_W-1:0] nest_in;
   logic do_push;
   logic [hidrdp_pkg::SI_W-1:0] push_idx, pop_idx;
   hidrdp_pkg::rec_type rec;

   assign in_pop    = !in_empty && (cnt_ff != 2'd2);
   assign out_empty = cnt_ff == 2'd0;
   assign out_rec   = q_ff[rp_ff];
   assign push_idx  = sp_ff[hidrdp_pkg::SI_W-1:0];
   assign pop_idx   = hidrdp_pkg::SI_W'(sp_ff - 1'b1);

   always_comb begin
      logic [3:0] t;
      logic [2:0] st;
      logic       app;
      logic [31:0] usage;
      gt_in   = gt_ff;
      lu_in   = lu_ff;
      sp_in   = sp_ff;
      nest_in = nest_ff;
      do_push = 1'b0;
      st      = hidrdp_pkg::ST_OK;
      t       = in_item.tag[3:0];
      app     = !in_item.trunc && !in_item.is_long;
      usage   = lu_ff;
      if (in_item.trunc) st = hidrdp_pkg::ST_TRUNC;
      if (app) begin
         case (in_item.itype)
            hidrdp_pkg::ITYPE_MAIN: begin
               if (t == hidrdp_pkg::TAG_COLLECTION) begin
                  if (nest_ff < hidrdp_pkg::NEST_W'(hidrdp_pkg::MAX_NEST))
                     nest_in = nest_ff + 1'b1;
               end else if (t == hidrdp_pkg::TAG_END_COLL) begin
                  if (nest_ff == '0) st = hidrdp_pkg::ST_DEPTH_UNF;
                  else nest_in = nest_ff - 1'b1;
               end
               lu_in = '0;
            end
            hidrdp_pkg::ITYPE_GLOBAL: begin
               if (t == hidrdp_pkg::TAG_PUSH) begin
                  if (sp_ff >= hidrdp_pkg::SP_W'(hidrdp_pkg::STACK_DEPTH)) begin
                     st = hidrdp_pkg::ST_PUSH_OVF;
                  end else begin
                     do_push = 1'b1;
                     sp_in   = sp_ff + 1'b1;
                  end
               end else if (t == hidrdp_pkg::TAG_POP) begin
                  if (sp_ff == '0) begin
                     for (int i = 0; i < 16; i++) gt_in[i] = '0;
                     st = hidrdp_pkg::ST_POP_EMPTY;
                  end else begin
                     sp_in = sp_ff - 1'b1;
                     gt_in = gs_ff[pop_idx];
                  end
               end else begin
                  gt_in[t] = in_item.value;
               end
            end
            hidrdp_pkg::ITYPE_LOCAL: begin
               if (t == hidrdp_pkg::L_USAGE) lu_in = in_item.value;
            end
            default: ;
         endcase
         if (in_item.itype != hidrdp_pkg::ITYPE_MAIN) usage = lu_in;
      end
      rec.is_long      = in_item.is_long;
      rec.itype        = in_item.itype;
      rec.item_tag     = in_item.tag;
      rec.data_size    = in_item.size;
      rec.data_value   = in_item.value;
      rec.nest_depth   = 5'(nest_in);
      rec.usage_page   = gt_in[hidrdp_pkg::G_USAGE_PAGE];
      rec.report_size  = gt_in[hidrdp_pkg::G_REPORT_SIZE];
      rec.report_id    = gt_in[hidrdp_pkg::G_REPORT_ID];
      rec.report_count = gt_in[hidrdp_pkg::G_REPORT_COUNT];
      rec.local_usage  = usage;
      rec.status       = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) gt_ff[i] <= '0;
         lu_ff   <= '0;
         sp_ff   <= '0;
         nest_ff <= '0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (in_pop) begin
            if (in_item.last) begin
               for (int i = 0; i < 16; i++) gt_ff[i] <= '0;
               lu_ff   <= '0;
               sp_ff   <= '0;
               nest_ff <= '0;
            end else begin
               gt_ff   <= gt_in;
               lu_ff   <= lu_in;
               sp_ff   <= sp_in;
               nest_ff <= nest_in;
            end
            wp_ff <= !wp_ff;
         end
         if (out_pop && !out_empty) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, in_pop} - {1'b0, out_pop && !out_empty};
      end
      if (in_pop) q_ff[wp_ff] <= rec;
      if (in_pop && do_push) gs_ff[push_idx] <= gt_ff;
   end
endmodule
`default_nettype wire

FILE: rtl/hid_report_descriptor_parser_unit.sv
// HID report descriptor parser, top level: byte assembler, item queue and table
// engine. Depends on hidrdp_pkg and the hidrdp_* modules. One descriptor byte
// per cycle unless req_full. Items pass the item queue, records the output
// queue. The engine applies one item per cycle while the output queue has room.
// Synchronous reset clears all parse state, tables and queues; no clearing pass.
`default_nettype none
module hid_report_descriptor_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_desc_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_is_long,
   output logic [1:0]       rsp_item_type,
   output logic [7:0]       rsp_item_tag,
   output logic [7:0]       rsp_data_size,
   output logic [31:0]      rsp_data_value,
   output logic [4:0]       rsp_nest_depth,
   output logic [31:0]      rsp_usage_page,
   output logic [31:0]      rsp_report_size,
   output logic [31:0]      rsp_report_id,
   output logic [31:0]      rsp_report_count,
   output logic [31:0]      rsp_local_usage,
   output logic [2:0]       rsp_status
);
   logic accept, f_valid, q_full, q_empty, q_pop;
   hidrdp_pkg::item_type f_item, q_item;
   hidrdp_pkg::rec_type  rec;

   // A full item queue stalls the whole byte stream.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   hidrdp_front u_front (
      .clock, .reset, .in_valid(accept), .in_byte(req_desc_byte),
      .in_last(req_last_byte), .item_valid(f_valid), .item(f_item)
   );

   hidrdp_queue u_queue (
      .clock, .reset, .wr_en(f_valid), .wr_item(f_item), .full(q_full),
      .rd_en(q_pop), .empty(q_empty), .rd_item(q_item)
   );

   hidrdp_back u_back (
      .clock, .reset, .in_empty(q_empty), .in_item(q_item), .in_pop(q_pop),
      .out_pop(rsp_pop), .out_empty(rsp_empty), .out_rec(rec)
   );

   assign rsp_is_long      = rec.is_long;
   assign rsp_item_type    = rec.itype;
   assign rsp_item_tag     = rec.item_tag;
   assign rsp_data_size    = rec.data_size;
   assign rsp_data_value   = rec.data_value;
   assign rsp_nest_depth   = rec.nest_depth;
   assign rsp_usage_page   = rec.usage_page;
   assign rsp_report_size  = rec.report_size;
   assign rsp_report_id    = rec.report_id;
   assign rsp_report_count = rec.report_count;
   assign rsp_local_usage  = rec.local_usage;
   assign rsp_status       = rec.status;
endmodule
`default_nettype wire

FILE: tb/sv/hidrdp_checker.sv
// Checker for the HID report descriptor parser: watches the byte and record
// ports, predicts each record and compares. Depends on hidrdp_pkg.
`default_nettype none
module hidrdp_checker
   import hidrdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [7:0]  req_desc_byte,
   input  wire logic        req_last_byte,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic        rsp_is_long,
   input  wire logic [1:0]  rsp_item_type,
   input  wire logic [7:0]  rsp_item_tag,
   input  wire logic [7:0]  rsp_data_size,
   input  wire logic [31:0] rsp_data_value,
   input  wire logic [4:0]  rsp_nest_depth,
   input  wire logic [31:0] rsp_usage_page,
   input  wire logic [31:0] rsp_report_size,
   input  wire logic [31:0] rsp_report_id,
   input  wire logic [31:0] rsp_report_count,
   input  wire logic [31:0] rsp_local_usage,
   input  wire logic [2:0]  rsp_status,
   output int               fail_count,
   output int               pending_records,
   output int               record_count
);
   rec_type     record_queue[$];
   phase_type   phase;
   logic [7:0]  remaining, hdr_byte, long_tag, length;
   logic [31:0] assembled;
   logic [31:0] globals[16];
   logic [31:0] saved[STACK_DEPTH][16];
   logic [31:0] locals[16];
   int          depth_held;
   int          nest;
   int          status_seen[8];

   function automatic rec_type make_record(logic lng, logic [7:0] tag,
                                           logic [31:0] usage, status_type st);
      rec_type r;
      r.is_long      = lng;
      r.itype        = hdr_byte[3:2];
      r.item_tag     = tag;
      r.data_size    = length;
      r.data_value   = assembled;
      r.nest_depth   = nest[4:0];
      r.usage_page   = globals[G_USAGE_PAGE];
      r.report_size  = globals[G_REPORT_SIZE];
      r.report_id    = globals[G_REPORT_ID];
      r.report_count = globals[G_REPORT_COUNT];
      r.local_usage  = usage;
      r.status       = st;
      return r;
   endfunction

   // Appends a predicted record behind the ones still waiting.
   task automatic queue_record(rec_type r);
      record_queue.insert(record_queue.size(), r);
   endtask

   task automatic clear_parser();
      phase = PH_HEADER; remaining = 0; hdr_byte = 0; long_tag = 0;
      length = 0; assembled = 0; depth_held = 0; nest = 0;
      for (int i = 0; i < 16; i++) begin
         globals[i] = 0;
         locals[i] = 0;
      end
   endtask

   // Applies a finished item to the tables and queues its record.
   task automatic apply_item();
      logic [3:0] stag;
      itype_type  ity;
      status_type st;
      logic [31:0] usage;
      stag = hdr_byte[7:4];
      ity = itype_type'(hdr_byte[3:2]);
      st = ST_OK;
      if (stag == TAG_LONG) begin
         queue_record(make_record(1'b1, long_tag, locals[0], ST_OK));
         return;
      end
      case (ity)
         ITYPE_MAIN: begin
            if (stag == TAG_COLLECTION) begin
               if (nest < MAX_NEST) nest++;
            end else if (stag == TAG_END_COLL) begin
               if (nest == 0) st = ST_DEPTH_UNF;
               else nest--;
            end
            usage = locals[0];
            for (int i = 0; i < 16; i++) locals[i] = 0;
            queue_record(make_record(1'b0, {4'd0, stag}, usage, st));
            status_seen[st]++;
            return;
         end
         ITYPE_GLOBAL: begin
            if (stag == TAG_PUSH) begin
               if (depth_held >= STACK_DEPTH) st = ST_PUSH_OVF;
               else begin
                  saved[depth_held] = globals;
                  depth_held++;
               end
            end else if (stag == TAG_POP) begin
               if (depth_held == 0) begin
                  for (int i = 0; i < 16; i++) globals[i] = 0;
                  st = ST_POP_EMPTY;
               end else begin
                  depth_held--;
                  globals = saved[depth_held];
               end
            end else globals[stag] = assembled;
         end
         ITYPE_LOCAL: locals[stag] = assembled;
         default: ;
      endcase
      status_seen[st]++;
      queue_record(make_record(1'b0, {4'd0, stag}, locals[0], st));
   endtask

   task automatic take_byte(logic [7:0] b, logic last);
      logic done;
      logic [7:0] got;
      done = 1'b0;
      case (phase)
         PH_HEADER: begin
            hdr_byte = b; long_tag = 0; assembled = 0; length = 0; remaining = 0;
            if (b[7:4] == TAG_LONG) phase = PH_LSIZE;
            else begin
               length = (b[1:0] == 2'd3) ? 8'd4 : {6'd0, b[1:0]};
               remaining = length;
               if (length == 0) done = 1'b1;
               else phase = PH_DATA;
            end
         end
         PH_LSIZE: begin
            length = b; remaining = b; phase = PH_LTAG;
         end
         PH_LTAG: begin
            long_tag = b;
            if (length == 0) done = 1'b1;
            else phase = PH_DATA;
         end
         default: begin
            got = length - remaining;
            if (got < 4) assembled |= 32'(b) << (8 * got);
            if (remaining > 0) remaining--;
            if (remaining == 0) done = 1'b1;
         end
      endcase
      if (done) begin
         phase = PH_HEADER;
         apply_item();
         if (last) clear_parser();
      end else if (last) begin
         if (hdr_byte[7:4] == TAG_LONG)
            queue_record(make_record(1'b1, long_tag, locals[0], ST_TRUNC));
         else
            queue_record(make_record(1'b0, {4'd0, hdr_byte[7:4]}, locals[0], ST_TRUNC));
         status_seen[ST_TRUNC]++;
         clear_parser();
      end
   endtask

   initial begin
      fail_count = 0;
      record_count = 0;
      pending_records = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      clear_parser();
   end

   always @(posedge clock) begin
      rec_type want, seen;
      if (reset) begin
         record_queue.delete();
         clear_parser();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen = {rsp_is_long, rsp_item_type, rsp_item_tag, rsp_data_size,
                    rsp_data_value, rsp_nest_depth, rsp_usage_page, rsp_report_size,
                    rsp_report_id, rsp_report_count, rsp_local_usage, rsp_status};
            record_count++;
            if (record_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected record %p", seen);
            end else begin
               want = record_queue.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("record mismatch\n  expected %p\n  actual   %p", want, seen);
               end
            end
         end
         if (req_push && !req_full) take_byte(req_desc_byte, req_last_byte);
      end
      pending_records = record_queue.size();
   end
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench top for the HID report descriptor parser: makes byte stimulus and
// gives the verdict. Depends on hidrdp_pkg, hidrdp_checker and the RTL.
`default_nettype none
module tb_top;
   import hidrdp_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic        clock, reset;
   logic        req_push, req_full, req_last_byte;
   logic [7:0]  req_desc_byte;
   logic        rsp_empty, rsp_pop, rsp_is_long;
   logic [1:0]  rsp_item_type;
   logic [7:0]  rsp_item_tag, rsp_data_size;
   logic [31:0] rsp_data_value, rsp_usage_page, rsp_report_size;
   logic [31:0] rsp_report_id, rsp_report_count, rsp_local_usage;
   logic [4:0]  rsp_nest_depth;
   logic [2:0]  rsp_status;
   int          fail_count, pending_records, record_count;
   int          idle_cycles;
   logic        calm, hold_off;
   logic [7:0]  byte_list[$];
   logic        last_list[$];
   int          words_sent;

   hid_report_descriptor_parser_unit u_dut (.*);
   hidrdp_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Receiver: random pops, no idling while calm, none at all during hold-off.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_pop <= 1'b0;
      else rsp_pop <= calm || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic add(logic [7:0] b, logic last = 1'b0);
      byte_list.insert(byte_list.size(), b);
      last_list.insert(last_list.size(), last);
   endtask

   // A short item with random payload of the given size code.
   task automatic add_short(logic [3:0] tag, logic [1:0] ity, logic [1:0] code);
      int n;
      add({tag, ity, code});
      n = (code == 3) ? 4 : code;
      for (int i = 0; i < n; i++) add(8'($urandom));
   endtask

   task automatic add_long(int n);
      add({4'hF, 2'($urandom), 2'($urandom)});
      add(8'(n));
      add(8'($urandom));
      for (int i = 0; i < n; i++) add(8'($urandom));
   endtask

   // A mostly well-formed descriptor with random content.
   task automatic add_descriptor();
      int n;
      n = $urandom_range(4, 30);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0: add_short(TAG_COLLECTION, ITYPE_MAIN, 2'($urandom));
            1: add_short(TAG_END_COLL, ITYPE_MAIN, 2'($urandom));
            2: add_short(TAG_PUSH, ITYPE_GLOBAL, 2'($urandom));
            3: add_short(TAG_POP, ITYPE_GLOBAL, 2'($urandom));
            4: add_short(4'($urandom_range(14)), ITYPE_GLOBAL, 2'($urandom));
            5: add_short(4'($urandom_range(14)), ITYPE_LOCAL, 2'($urandom));
            6: add_short(4'($urandom_range(14)), itype_type'($urandom), 2'($urandom));
            7: add_long($urandom_range(0, 6));
            8: add(8'($urandom));
            default: add_short(4'($urandom_range(14)), ITYPE_MAIN, 2'($urandom));
         endcase
      end
      if ($urandom_range(3) == 0) add(8'($urandom));
      last_list[$] = 1'b1;
   endtask

   task automatic send_all();
      while (byte_list.size() > 0) begin
         if (calm || $urandom_range(99) >= 26) begin
            req_push <= 1'b1;
            req_desc_byte <= byte_list[0];
            req_last_byte <= last_list[0];
            @(posedge clock);
            while (req_full) @(posedge clock);
            void'(byte_list.pop_front());
            void'(last_list.pop_front());
            words_sent++;
         end else begin
            req_push <= 1'b0;
            req_desc_byte <= 8'($urandom);
            req_last_byte <= 1'($urandom);
            @(posedge clock);
         end
      end
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset = 1; req_push = 0; req_desc_byte = 0; req_last_byte = 0;
      calm = 0; hold_off = 0; words_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty items, pop on empty, push overflow, underflow, long,
      // all-ones bytes and a truncated long item.
      add(8'h00); add(8'hB4); add_short(4'd0, ITYPE_GLOBAL, 2'd3);
      for (int i = 0; i < 5; i++) add_short(TAG_PUSH, ITYPE_GLOBAL, 2'd0);
      add_short(TAG_END_COLL, ITYPE_MAIN, 2'd0);
      add_short(4'd7, ITYPE_GLOBAL, 2'd3);
      add_short(4'd0, ITYPE_LOCAL, 2'd2);
      add(8'hFF); add(8'd2); add(8'hFF); add(8'hFF); add(8'hFF);
      add(8'hFE); add(8'd0); add(8'h5A);
      add(8'hF3); add(8'd9); add(8'hFF, 1'b1);
      send_all();

      // Nest past the maximum, then a truncated short item.
      for (int i = 0; i < MAX_NEST + 2; i++) add_short(TAG_COLLECTION, ITYPE_MAIN, 2'd0);
      add(8'h93); add(8'h11, 1'b1);
      send_all();

      // Fill the block while the receiver holds off.
      hold_off = 1;
      for (int i = 0; i < 6; i++) add_descriptor();
      fork
         send_all();
         begin repeat (300) @(posedge clock); hold_off = 0; end
      join

      while (words_sent < 1950) begin
         calm = (words_sent > 900 && words_sent < 1200);
         add_descriptor();
         send_all();
      end
      calm = 0;
      while (pending_records != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d descriptor bytes sent, %0d records compared", words_sent, record_count);
      $display("pop on empty %0d, push overflow %0d, underflow %0d, truncated %0d",
               u_checker.status_seen[ST_POP_EMPTY], u_checker.status_seen[ST_PUSH_OVF],
               u_checker.status_seen[ST_DEPTH_UNF], u_checker.status_seen[ST_TRUNC]);
      if (fail_count == 0 && pending_records == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/hidrdp_pkg.sv
rtl/hidrdp_front.sv
rtl/hidrdp_queue.sv
rtl/hidrdp_back.sv
rtl/hid_report_descriptor_parser_unit.sv
tb/sv/hidrdp_checker.sv
tb/sv/tb_top.sv
